FILE: rtl/esf_pkg.sv
// ----------------------------------------------------------------------------
// esf_pkg
// Shared types and constants of the encoder-to-servo follower.
// ----------------------------------------------------------------------------
package esf_pkg;

    // Default sizes of the position counter and the debounce quiet-time counter
    localparam int POSITION_WIDTH_DEF = 32;
    localparam int QUIET_WIDTH_DEF    = 16;

    // Configuration register widths and indexes
    localparam int DEBOUNCE_W = 16;
    localparam int OFFSET_W   = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LIMIT  = 2'd2;

    // Register reset values
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [OFFSET_W-1:0]   OFFSET_RESET   = 12'd2048;
    localparam logic [OFFSET_W-1:0]   LIMIT_RESET    = 12'd4095;

    // Gain step codes
    localparam logic [1:0] GAIN_HALF   = 2'd0;
    localparam logic [1:0] GAIN_UNITY  = 2'd1;
    localparam logic [1:0] GAIN_DOUBLE = 2'd2;
    localparam logic [1:0] GAIN_QUAD   = 2'd3;

    // Count is clamped to this span before scaling
    localparam logic signed [15:0] CLAMP_HI = 16'sd16384;
    localparam logic signed [15:0] CLAMP_LO = -16'sd16384;

    // Scaled count plus offset: +-65536 + 4095 fits in 19 signed bits
    localparam int SCALE_W = 19;

    localparam int POS_OUT_W = 32;

    // Flags that travel with one transaction from the tracker to the target stage
    typedef struct packed {
        logic [1:0] gain_index;
        logic       move;
        logic       gain_changed;
    } esf_flags_t;

endpackage

FILE: rtl/esf_track.sv
// ----------------------------------------------------------------------------
// esf_track
// Quadrature decode, button debounce and gain step; one transaction per cycle unless the target stage stalls.
// ----------------------------------------------------------------------------
module esf_track import esf_pkg::*; #(
    parameter int PW = POSITION_WIDTH_DEF,
    parameter int QW = QUIET_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  a_level,
    input  logic                  b_level,
    input  logic                  button_level,
    input  logic                  ms_tick,
    input  logic [DEBOUNCE_W-1:0] debounce_ms,
    output logic                  mid_valid,
    input  logic                  mid_ready,
    output logic [PW-1:0]         mid_count,
    output esf_flags_t            mid_flags
);

    localparam int CMP_W = (QW > DEBOUNCE_W) ? QW : DEBOUNCE_W;
    localparam logic [QW-1:0] QUIET_MAX = {QW{1'b1}};

    logic          primed_reg,  primed_next;
    logic          prev_a_reg,  prev_b_reg;
    logic [PW-1:0] count_reg,   count_next;
    logic          raw_prev_reg;
    logic          stable_reg,  stable_next;
    logic [QW-1:0] quiet_reg,   quiet_next;
    logic [1:0]    gain_reg,    gain_next;
    logic          mid_valid_reg;
    logic [PW-1:0] mid_count_reg;
    esf_flags_t    mid_flags_reg;

    logic          accept;
    logic          chg_a, chg_b;
    logic [PW-1:0] count_enc;
    logic [PW-1:0] count_before;
    logic          press;
    logic          level_ok;
    logic          move;

    assign in_ready = !mid_valid_reg || mid_ready;
    assign accept   = in_valid && in_ready;

    // The commanded count always equals the count left by the previous item,
    // so only the count itself is kept.
    always_comb begin
        chg_a     = a_level != prev_a_reg;
        chg_b     = b_level != prev_b_reg;
        count_enc = count_reg;
        // One channel moved: step; both moved: the two rules cancel
        if (primed_reg && (chg_a ^ chg_b)) begin
            if (chg_a ^ (a_level == b_level)) begin
                count_enc = count_reg + PW'(1);
            end else begin
                count_enc = count_reg - PW'(1);
            end
        end
        primed_next = 1'b1;

        if (button_level != raw_prev_reg) begin
            quiet_next = '0;
        end else if (ms_tick && quiet_reg != QUIET_MAX) begin
            quiet_next = quiet_reg + QW'(1);
        end else begin
            quiet_next = quiet_reg;
        end

        level_ok    = (CMP_W'(quiet_next) > CMP_W'(debounce_ms))
                      && (button_level != stable_reg);
        press       = level_ok && !button_level;
        stable_next = level_ok ? button_level : stable_reg;
        gain_next   = press ? gain_reg + 2'd1 : gain_reg;
        count_next  = press ? '0 : count_enc;
        count_before = press ? '0 : count_reg;
        move        = count_next != count_before;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg    <= 1'b0;
            prev_a_reg    <= 1'b0;
            prev_b_reg    <= 1'b0;
            count_reg     <= '0;
            raw_prev_reg  <= 1'b1;
            stable_reg    <= 1'b0;
            quiet_reg     <= '0;
            gain_reg      <= GAIN_UNITY;
            mid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                primed_reg   <= primed_next;
                prev_a_reg   <= a_level;
                prev_b_reg   <= b_level;
                count_reg    <= count_next;
                raw_prev_reg <= button_level;
                stable_reg   <= stable_next;
                quiet_reg    <= quiet_next;
                gain_reg     <= gain_next;
            end
            if (accept) begin
                mid_valid_reg <= 1'b1;
            end else if (mid_ready) begin
                mid_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mid_count_reg              <= count_next;
            mid_flags_reg.gain_index   <= gain_next;
            mid_flags_reg.move         <= move;
            mid_flags_reg.gain_changed <= press;
        end
    end

    assign mid_valid = mid_valid_reg;
    assign mid_count = mid_count_reg;
    assign mid_flags = mid_flags_reg;

    // Gain holds unless a transaction is taken
    a_gain_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(gain_reg))
        else $error("gain step moved without a transaction");

    // A gain advance always comes with a zeroed count
    a_press_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        mid_valid_reg && mid_flags_reg.gain_changed |-> mid_count_reg == '0)
        else $error("gain advanced but count not cleared");

    // The forwarded count is the tracked count of the last transaction
    a_count_fwd: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> mid_count_reg == count_reg)
        else $error("forwarded count differs from tracked count");

    // Gain advances by exactly one step on a press
    a_gain_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && press |=> gain_reg == $past(gain_reg) + 2'd1)
        else $error("gain step did not advance by one");

endmodule

FILE: rtl/esf_target.sv
// ----------------------------------------------------------------------------
// esf_target
// Servo target scaling and clamping, and the result register.
// ----------------------------------------------------------------------------
module esf_target import esf_pkg::*; #(
    parameter int PW = POSITION_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 mid_valid,
    output logic                 mid_ready,
    input  logic [PW-1:0]        mid_count,
    input  esf_flags_t           mid_flags,
    input  logic [OFFSET_W-1:0]  center_offset,
    input  logic [OFFSET_W-1:0]  target_limit,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [POS_OUT_W-1:0] out_position,
    output esf_flags_t           out_flags,
    output logic [OFFSET_W-1:0]  out_target
);

    logic                 out_valid_reg;
    logic [POS_OUT_W-1:0] pos_reg;
    esf_flags_t           flags_reg;
    logic [OFFSET_W-1:0]  target_reg;

    logic signed [PW-1:0]      cnt_s;
    logic signed [15:0]        clamped;
    logic signed [15:0]        rnd;
    logic signed [15:0]        half;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [SCALE_W-1:0] off_s;
    logic signed [SCALE_W-1:0] lim_s;
    logic signed [SCALE_W-1:0] sum;
    logic [OFFSET_W-1:0]       target;
    logic                      load;

    assign mid_ready = !out_valid_reg || out_ready;
    assign load      = mid_valid && mid_ready;

    always_comb begin
        cnt_s = mid_count;
        if (cnt_s > PW'(CLAMP_HI)) begin
            clamped = CLAMP_HI;
        end else if (cnt_s < PW'(CLAMP_LO)) begin
            clamped = CLAMP_LO;
        end else begin
            clamped = 16'(cnt_s);
        end
        // Half gain truncates toward zero: bias negatives by one before the shift
        rnd  = {15'b0, clamped[15]};
        half = (clamped + rnd) >>> 1;
        case (mid_flags.gain_index)
            GAIN_HALF:   scaled = SCALE_W'(half);
            GAIN_UNITY:  scaled = SCALE_W'(clamped);
            GAIN_DOUBLE: scaled = (SCALE_W'(clamped)) <<< 1;
            GAIN_QUAD:   scaled = (SCALE_W'(clamped)) <<< 2;
            default:     scaled = SCALE_W'(clamped);
        endcase
        off_s = SCALE_W'(center_offset);
        lim_s = SCALE_W'(target_limit);
        sum   = off_s + scaled;
        if (sum < 0) begin
            target = '0;
        end else if (sum > lim_s) begin
            target = target_limit;
        end else begin
            target = OFFSET_W'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pos_reg    <= POS_OUT_W'(cnt_s);
            flags_reg  <= mid_flags;
            target_reg <= target;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_position = pos_reg;
    assign out_flags    = flags_reg;
    assign out_target   = target_reg;

    // The clamp keeps every new target within the limit
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> target_reg <= $past(target_limit))
        else $error("target above limit");

    // Zero count with the limit at or above the offset gives the offset
    a_center: assert property (@(posedge aclk) disable iff (!aresetn)
        load && mid_count == '0 && target_limit >= center_offset
        |=> target_reg == $past(center_offset))
        else $error("zero count does not map to the center offset");

    // A stalled result keeps its target
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_ready |=> $stable(target_reg))
        else $error("stalled result changed");

endmodule

FILE: rtl/encoder_to_servo_follower.sv
// ----------------------------------------------------------------------------
// encoder_to_servo_follower
// Quadrature encoder follower with debounced gain select and servo target.
// ----------------------------------------------------------------------------
// Path: a result is registered in the tracker register, then in the
//   target/result register.
// Throughput: 1 transaction per cycle unless the result stream stalls; the
//   tracker updates its state as it takes a sample, so samples may arrive back to back.
// Reset: aresetn is synchronous, active low; it clears both pipeline stages,
//   the count and debounce state, sets unity gain and the register defaults.
module encoder_to_servo_follower import esf_pkg::*; #(
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEF,
    parameter int QUIET_WIDTH    = QUIET_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // a_level, b_level, button_level, ms_tick, 0...
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // position[31:0], gain_index[1:0],
                                             // target_position[11:0], move, gain_changed
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic [DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [OFFSET_W-1:0]   center_offset_reg;
    logic [OFFSET_W-1:0]   target_limit_reg;

    // Tracker to target stage
    logic                      mid_valid;
    logic                      mid_ready;
    logic [POSITION_WIDTH-1:0] mid_count;
    esf_flags_t                mid_flags;

    // Result register contents
    logic [POS_OUT_W-1:0] out_position;
    esf_flags_t           out_flags;
    logic [OFFSET_W-1:0]  out_target;

    // Take register writes directly; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg   <= DEBOUNCE_RESET;
            center_offset_reg <= OFFSET_RESET;
            target_limit_reg  <= LIMIT_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data;
                REG_CENTER_OFFSET: center_offset_reg <= cfg_data[OFFSET_W-1:0];
                REG_TARGET_LIMIT:  target_limit_reg  <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: decode encoder edges, debounce the button, advance gain
    esf_track #(
        .PW (POSITION_WIDTH),
        .QW (QUIET_WIDTH)
    ) u_track (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .a_level      (s_tdata[0]),
        .b_level      (s_tdata[1]),
        .button_level (s_tdata[2]),
        .ms_tick      (s_tdata[3]),
        .debounce_ms  (debounce_ms_reg),
        .mid_valid    (mid_valid),
        .mid_ready    (mid_ready),
        .mid_count    (mid_count),
        .mid_flags    (mid_flags)
    );

    // Stage 2: scale and clamp the target, hold the result until taken
    esf_target #(
        .PW (POSITION_WIDTH)
    ) u_target (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .mid_valid     (mid_valid),
        .mid_ready     (mid_ready),
        .mid_count     (mid_count),
        .mid_flags     (mid_flags),
        .center_offset (center_offset_reg),
        .target_limit  (target_limit_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_position  (out_position),
        .out_flags     (out_flags),
        .out_target    (out_target)
    );

    // Pack the result fields, highest field first
    assign m_tdata = {out_flags.gain_changed, out_flags.move, out_target,
                      out_flags.gain_index, out_position};

endmodule

FILE: tb/esf_follower_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esf_follower_checker
// Watches the sample stream, the result stream and the register port of the
// encoder follower. It predicts each result from its own copy of the tracker
// state and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module esf_follower_checker import esf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // a_level, b_level, button_level, ms_tick, 0...
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [47:0]           m_tdata,   // position[31:0], gain_index[1:0],
                                             // target_position[11:0], move, gain_changed
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    err_count,
    output int                    outstanding,
    output int                    results_seen,
    output int                    gain_steps_seen
);

    // Same layout as m_tdata, highest field first
    typedef struct packed {
        logic                 gain_changed;
        logic                 move;
        logic [OFFSET_W-1:0]  target;
        logic [1:0]           gain;
        logic [POS_OUT_W-1:0] position;
    } follower_result_t;

    logic [DEBOUNCE_W-1:0]      debounce_ms;
    logic [OFFSET_W-1:0]        center_offset;
    logic [OFFSET_W-1:0]        target_limit;

    logic                       primed;
    logic                       prev_a;
    logic                       prev_b;
    logic [POS_OUT_W-1:0]       count;
    logic [POS_OUT_W-1:0]       commanded;
    logic                       raw_btn_prev;
    logic                       stable_btn;
    logic [QUIET_WIDTH_DEF-1:0] quiet_time;
    logic [1:0]                 gain_step;

    follower_result_t pending_results[$];

    task automatic reset_tracker();
        debounce_ms   = DEBOUNCE_RESET;
        center_offset = OFFSET_RESET;
        target_limit  = LIMIT_RESET;
        primed        = 1'b0;
        prev_a        = 1'b0;
        prev_b        = 1'b0;
        count         = '0;
        commanded     = '0;
        raw_btn_prev  = 1'b1;
        stable_btn    = 1'b0;
        quiet_time    = '0;
        gain_step     = GAIN_UNITY;
    endtask

    task automatic log_error(input string msg);
        err_count++;
        $display("ERROR %0t ns: %s", $time, msg);
    endtask

    // Advance the tracker by one sample: encoder, then debounce, then target
    function automatic follower_result_t follow_sample(input logic [3:0] pins);
        logic             a;
        logic             b;
        logic             btn;
        logic             tick;
        logic             changed;
        int               c;
        int               scaled;
        int               tgt;
        follower_result_t r;
        a       = pins[0];
        b       = pins[1];
        btn     = pins[2];
        tick    = pins[3];
        changed = 1'b0;

        if (!primed) begin
            primed = 1'b1;
        end else begin
            if (a != prev_a) count = (a == b) ? count - 1 : count + 1;
            if (b != prev_b) count = (a == b) ? count + 1 : count - 1;
        end
        prev_a = a;
        prev_b = b;

        if (btn != raw_btn_prev) begin
            quiet_time = '0;
        end else if (tick && quiet_time != '1) begin
            quiet_time = quiet_time + 1'b1;
        end
        if (quiet_time > debounce_ms && btn != stable_btn) begin
            stable_btn = btn;
            if (!btn) begin
                gain_step = gain_step + 2'd1;
                count     = '0;
                commanded = '0;
                changed   = 1'b1;
            end
        end
        raw_btn_prev = btn;

        r.move = (count != commanded);
        if (r.move) commanded = count;

        c = $signed(count);
        if (c > CLAMP_HI) c = CLAMP_HI;
        if (c < CLAMP_LO) c = CLAMP_LO;
        case (gain_step)
            GAIN_HALF:   scaled = c / 2;
            GAIN_UNITY:  scaled = c;
            GAIN_DOUBLE: scaled = c * 2;
            default:     scaled = c * 4;
        endcase
        tgt = int'(center_offset) + scaled;
        if (tgt < 0) tgt = 0;
        if (tgt > int'(target_limit)) tgt = int'(target_limit);

        r.position     = count;
        r.gain         = gain_step;
        r.target       = tgt[OFFSET_W-1:0];
        r.gain_changed = changed;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        follower_result_t want;
        follower_result_t got;
        if (!aresetn) begin
            reset_tracker();
            pending_results.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    REG_DEBOUNCE_MS:   debounce_ms   = cfg_data[DEBOUNCE_W-1:0];
                    REG_CENTER_OFFSET: center_offset = cfg_data[OFFSET_W-1:0];
                    REG_TARGET_LIMIT:  target_limit  = cfg_data[OFFSET_W-1:0];
                    default: ;
                endcase
            end
            // Pop before push so a stray result never pairs with a fresh sample
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (got.gain_changed === 1'b1) gain_steps_seen++;
                if (pending_results.size() == 0) begin
                    log_error($sformatf("result %h with no sample waiting", m_tdata));
                end else begin
                    want = pending_results.pop_front();
                    if (got.position !== want.position)
                        log_error($sformatf("position got %0d want %0d",
                                            $signed(got.position), $signed(want.position)));
                    if (got.gain !== want.gain)
                        log_error($sformatf("gain_index got %0d want %0d",
                                            got.gain, want.gain));
                    if (got.target !== want.target)
                        log_error($sformatf("target_position got %0d want %0d",
                                            got.target, want.target));
                    if (got.move !== want.move)
                        log_error($sformatf("move got %b want %b", got.move, want.move));
                    if (got.gain_changed !== want.gain_changed)
                        log_error($sformatf("gain_changed got %b want %b",
                                            got.gain_changed, want.gain_changed));
                end
            end
            if (s_tvalid && s_tready) pending_results.push_back(follow_sample(s_tdata[3:0]));
            outstanding <= pending_results.size();
        end
    end

endmodule

FILE: tb/encoder_to_servo_follower_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_to_servo_follower_tb
// Drives encoder, button and tick samples into the follower under several
// register settings and pacing modes; a checker beside the block predicts
// every result and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module encoder_to_servo_follower_tb;
    import esf_pkg::*;

    // Slowest correct run is roughly 1400 samples plus the one receiver hold-off of
    // HOLD_CYCLES; the limit leaves a wide margin over that.
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 300;
    // Two pipeline stages inside the block; wait a few more before the verdict
    localparam int TAIL_CYCLES = 10;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // a_level, b_level, button_level, ms_tick, 0...
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;   // position[31:0], gain_index[1:0],
                                      // target_position[11:0], move, gain_changed
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    int err_count;
    int outstanding;
    int results_seen;
    int gain_steps_seen;
    int cycles;
    int samples_sent;
    int settings_used;

    // Pacing knobs, set per phase by the stimulus and read by the sender and the receiver
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_requested;
    bit hold_served;

    // Random sample generator state: encoder levels, spin direction, button run
    logic enc_a;
    logic enc_b;
    logic spin_up;
    logic btn_lvl;
    int   btn_run;

    encoder_to_servo_follower dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    esf_follower_checker follower_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .cfg_we          (cfg_we),
        .cfg_idx         (cfg_idx),
        .cfg_data        (cfg_data),
        .err_count       (err_count),
        .outstanding     (outstanding),
        .results_seen    (results_seen),
        .gain_steps_seen (gain_steps_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog: fail the run at CYCLE_LIMIT, as when the block stops moving transactions
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side: stall at the phase's rate. On request, hold off once for a
    // long stretch so the pipeline fills and the block drops s_tready.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_requested && !hold_served) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_served = 1'b1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Pack one sample the way s_tdata carries it: a at bit 0 up to tick at bit 3
    function automatic logic [3:0] pins(input logic a, input logic b,
                                        input logic btn, input logic tick);
        return {tick, btn, b, a};
    endfunction

    // Offer one sample, idling first at the phase's rate; hold it until taken
    task automatic offer_sample(input logic [3:0] p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, p};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        samples_sent++;
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // Write all three registers on consecutive edges; only call while idle
    task automatic program_regs(input logic [DEBOUNCE_W-1:0] deb,
                                input logic [OFFSET_W-1:0] off,
                                input logic [OFFSET_W-1:0] lim);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_DEBOUNCE_MS;
        cfg_data <= deb;
        @(posedge aclk);
        cfg_idx  <= REG_CENTER_OFFSET;
        cfg_data <= CFG_DATA_W'(off);
        @(posedge aclk);
        cfg_idx  <= REG_TARGET_LIMIT;
        cfg_data <= CFG_DATA_W'(lim);
        @(posedge aclk);
        cfg_we   <= 1'b0;
        settings_used++;
    endtask

    // Mostly clean quadrature steps in a drifting direction with held button
    // runs long enough to pass the debounce; the rest is skipped encoder
    // states, random levels and short button bounces.
    function automatic logic [3:0] roll_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65) begin
            if (spin_up) begin
                if (enc_a == enc_b) enc_a = ~enc_a;
                else enc_b = ~enc_b;
            end else begin
                if (enc_a == enc_b) enc_b = ~enc_b;
                else enc_a = ~enc_a;
            end
            if ($urandom_range(15) == 0) spin_up = ~spin_up;
        end else if (pick < 75) begin
            enc_a = ~enc_a;
            enc_b = ~enc_b;
        end else if (pick < 85) begin
            enc_a = 1'($urandom_range(1));
            enc_b = 1'($urandom_range(1));
        end
        if (btn_run == 0) begin
            btn_lvl = ~btn_lvl;
            btn_run = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : $urandom_range(6, 20);
        end
        btn_run--;
        return pins(enc_a, enc_b, btn_lvl, $urandom_range(9) < 7);
    endfunction

    // One random phase: program the registers, set pacing, stream, then drain
    task automatic run_phase(input logic [DEBOUNCE_W-1:0] deb,
                             input logic [OFFSET_W-1:0] off,
                             input logic [OFFSET_W-1:0] lim,
                             input int send_pct, input int recv_pct,
                             input bit hold, input int n_samples);
        program_regs(deb, off, lim);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        hold_requested = hold;
        repeat (n_samples) offer_sample(roll_sample());
        drain();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_idx        = REG_DEBOUNCE_MS;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requested = 1'b0;
        hold_served    = 1'b0;
        enc_a          = 1'b0;
        enc_b          = 1'b0;
        spin_up        = 1'b1;
        btn_lvl        = 1'b1;
        btn_run        = 8;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part with zero debounce so presses land after one tick
        program_regs('0, OFFSET_RESET, LIMIT_RESET);
        // First sample only captures levels; the idle button level is accepted
        offer_sample(pins(1, 1, 1, 1));
        // One full clockwise cycle: each edge counts up
        offer_sample(pins(0, 1, 1, 0));
        offer_sample(pins(0, 0, 1, 0));
        offer_sample(pins(1, 0, 1, 0));
        offer_sample(pins(1, 1, 1, 0));
        // Both channels flip together: the two rules cancel
        offer_sample(pins(0, 0, 1, 0));
        // Step back once, then hold still
        offer_sample(pins(0, 1, 1, 1));
        offer_sample(pins(0, 1, 1, 1));
        // Press: the edge resets quiet time and ignores its tick, next one accepts
        offer_sample(pins(0, 1, 0, 1));
        offer_sample(pins(0, 1, 0, 1));
        offer_sample(pins(1, 1, 0, 0));
        // Release, then press again to reach quadruple gain
        offer_sample(pins(1, 1, 1, 1));
        offer_sample(pins(1, 1, 1, 1));
        offer_sample(pins(1, 1, 0, 1));
        offer_sample(pins(1, 1, 0, 1));
        // Once more to wrap around to half gain
        offer_sample(pins(1, 1, 1, 1));
        offer_sample(pins(1, 1, 1, 1));
        offer_sample(pins(1, 1, 0, 1));
        offer_sample(pins(1, 1, 0, 1));
        // Negative odd counts at half gain truncate toward zero
        offer_sample(pins(1, 0, 0, 0));
        offer_sample(pins(0, 0, 0, 0));
        offer_sample(pins(0, 1, 0, 0));
        offer_sample(pins(0, 1, 0, 0));
        drain();

        // Random phases: debounce, offset, limit, sender idle %, receiver stall %, hold-off request, samples
        run_phase('0,      12'd2048, 12'd4095, 0,  0,  1'b0, 190);
        run_phase(16'd3,   12'd0,    12'd4095, 79, 0,  1'b0, 190);
        run_phase(16'd2,   12'd4095, 12'd4095, 0,  79, 1'b0, 190);
        // Limit below the offset: the limit wins
        run_phase(16'd5,   12'd100,  12'd60,   12, 12, 1'b0, 190);
        // Debounce at its maximum is never reached; long receiver hold-off here
        run_phase('1,      12'd2000, 12'd2100, 0,  0,  1'b1, 190);
        run_phase(16'd1,   12'd4095, 12'd0,    12, 12, 1'b0, 190);
        run_phase(16'd4, OFFSET_W'($urandom_range(4095)), OFFSET_W'($urandom_range(4095)),
                  0, 79, 1'b0, 200);

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d samples and %0d results with %0d accepted button presses,",
                 samples_sent, results_seen, gain_steps_seen);
        $display("over %0d register settings, four pacing modes and one long receiver hold-off.",
                 settings_used);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
